FILE: rtl/fcsi_pkg.sv
// Shared types and constants for the fan curve sweep and lookup core.
package fcsi_pkg;

	localparam int PCT_W     = 7;
	localparam int RPM_W     = 16;
	localparam int DIV_NUM_W = 16;
	localparam int DIV_DEN_W = 7;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
	localparam int PROD_W    = 25;
	localparam int SUM_W     = PROD_W + 1;
	localparam int HELD_W    = 5;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic REG_MIN_PERCENT = 1'b0;
	localparam logic REG_MAX_PERCENT = 1'b1;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_T_DIV,
		ST_T_MUL,
		ST_T_END,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_DIV,
		ST_Q_MUL,
		ST_Q_ADD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

endpackage

FILE: rtl/fan_curve_sweep_and_interpolate_core.sv
// Fan curve sweep and interpolate core: top level with sequencer, table and result register.
// A start request goes straight from acceptance to the result load. A tick during a
// sweep forms the duty step by a reciprocal multiply, then the count-times-step product,
// then compares and writes the next duty, and then loads the result. A query reads and
// compares one table entry at a time (one read port on the table memories), and when it
// falls between two entries the slope also goes through the serial divider. Idle ticks,
// ignored commands and unanswered queries go straight to the result load.
// One request is in work at a time; a new one is taken while the previous result still waits
// on the output, and the input is held off while a finished result waits behind it.
module fan_curve_sweep_and_interpolate_core
	import fcsi_pkg::*;
#(
	parameter int SAMPLES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata: rpm_sample [15:0], query_percent [22:16], zero fill [23]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: command [1:0]
	input  logic [1:0]            s_tuser,
	// m_tdata: duty_percent [6:0], duty_valid [7], restore_default [8], sweep_busy [9],
	//          samples_held [14:10], query_rpm [30:15], rpm_valid [31]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int AW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int CW = $clog2(SAMPLES + 1);
	localparam int STEP_SH    = 16;
	localparam int STEP_PW    = STEP_SH + PCT_W;
	localparam int STEP_RECIP = (2**STEP_SH + SAMPLES - 1) / SAMPLES;

	state_t state_q, state_d;

	logic [PCT_W-1:0]  min_q, max_q;
	logic              running_q;
	logic [CW-1:0]     count_q;
	logic              m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [PCT_W-1:0]  duty_mem [SAMPLES];
	logic [RPM_W-1:0]  speed_mem [SAMPLES];
	logic [PCT_W-1:0]  rd_duty_q;
	logic [RPM_W-1:0]  rd_speed_q;

	logic [PCT_W-1:0]  pct_q;
	logic [AW-1:0]     idx_q;
	logic [PCT_W-1:0]  lo_duty_q;
	logic [RPM_W-1:0]  lo_speed_q;
	logic              neg_q;
	logic signed [7:0] step_q;
	logic signed [RPM_W:0] slope_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [PCT_W-1:0]  res_duty_q;
	logic              res_dvalid_q;
	logic              res_restore_q;
	logic [RPM_W-1:0]  res_qrpm_q;
	logic              res_rvalid_q;

	// request decode
	logic              acc;
	cmd_t              cmd;
	logic [RPM_W-1:0]  rpm_in;
	logic [PCT_W-1:0]  qpct_in;
	logic [PCT_W-1:0]  pct_hi;
	logic [PCT_W-1:0]  pct_clamp;
	logic              cnt_lt;
	logic              tick_run;
	logic signed [7:0] span;

	// search and interpolation
	logic              q_ge;
	logic [CW-1:0]     idx_next;
	logic              q_last;
	logic              q_interp;
	logic signed [RPM_W:0] sspan;
	logic [RPM_W:0]    sspan_mag;
	logic signed [7:0] dq;
	logic signed [PROD_W-1:0] qmul;
	logic signed [PROD_W-1:0] tmul;
	logic signed [SUM_W-1:0]  qsum;
	logic [RPM_W-1:0]  qsat;

	// sweep step
	logic [PCT_W-1:0]        span_mag;
	logic [STEP_PW-1:0]      step_prod;
	logic signed [7:0]       step_mag;
	logic signed [SUM_W-1:0] nxt;
	logic signed [SUM_W-1:0] nxt_lim;
	logic signed [SUM_W-1:0] mx_ext;
	logic signed [SUM_W-1:0] nxt_clamp;
	logic [PCT_W-1:0]        nxt_duty;
	logic                    t_end;

	// control
	div_req_t          div_req;
	logic [DIV_NUM_W-1:0] div_quo;
	logic              div_done;
	logic              out_free;
	logic              out_load;
	logic              duty_we;
	logic [AW-1:0]     duty_wa;
	logic [PCT_W-1:0]  duty_wd;
	logic              speed_we;
	logic              cfg_we;

	fcsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign acc     = s_tvalid & s_tready;
	assign cmd     = cmd_t'(s_tuser);
	assign rpm_in  = s_tdata[RPM_W-1:0];
	assign qpct_in = s_tdata[RPM_W+PCT_W-1:RPM_W];
	assign pct_hi    = (qpct_in > max_q) ? max_q : qpct_in;
	assign pct_clamp = (pct_hi < min_q) ? min_q : pct_hi;
	assign cnt_lt    = count_q < CW'(SAMPLES);
	assign tick_run  = running_q & cnt_lt;
	assign span      = $signed({1'b0, max_q}) - $signed({1'b0, min_q});

	assign q_ge      = pct_q >= rd_duty_q;
	assign idx_next  = CW'(idx_q) + CW'(1);
	assign q_last    = idx_next == count_q;
	assign q_interp  = !q_ge && (idx_q != '0) && (pct_q != lo_duty_q) && (rd_duty_q != lo_duty_q);
	assign sspan     = $signed({1'b0, rd_speed_q}) - $signed({1'b0, lo_speed_q});
	assign sspan_mag = sspan[RPM_W] ? 17'(-sspan) : 17'(sspan);
	assign dq        = $signed({1'b0, pct_q}) - $signed({1'b0, lo_duty_q});
	assign qmul      = PROD_W'(dq) * PROD_W'(slope_q);
	assign tmul      = PROD_W'($signed({1'b0, count_q})) * PROD_W'(step_q);
	assign qsum      = SUM_W'(prod_q) + $signed({{(SUM_W-RPM_W){1'b0}}, lo_speed_q});
	assign qsat      = qsum[SUM_W-1] ? '0 :
	                   (qsum > $signed(SUM_W'(65535))) ? 16'hFFFF : qsum[RPM_W-1:0];

	assign span_mag  = span[7] ? PCT_W'(-span) : PCT_W'(span);
	assign step_prod = STEP_PW'(span_mag) * STEP_PW'(STEP_RECIP);
	assign step_mag  = $signed({1'b0, step_prod[STEP_PW-1:STEP_SH]});
	assign nxt       = $signed({{(SUM_W-PCT_W){1'b0}}, min_q}) + SUM_W'(prod_q);
	assign mx_ext    = $signed({{(SUM_W-PCT_W){1'b0}}, max_q});
	assign nxt_lim   = mx_ext + SUM_W'(step_q);
	assign t_end     = !cnt_lt || (nxt > nxt_lim);
	assign nxt_clamp = (nxt > mx_ext) ? mx_ext : nxt;
	assign nxt_duty  = nxt_clamp[SUM_W-1] ? '0 :
	                   (nxt_clamp > $signed(SUM_W'(127))) ? 7'h7F : nxt_clamp[PCT_W-1:0];

	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (cmd)
						CMD_TICK:  state_d = tick_run ? ST_T_DIV : ST_FINISH;
						CMD_QUERY: state_d = (!running_q && count_q != '0) ? ST_Q_RD : ST_FINISH;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_T_DIV: state_d = ST_T_MUL;
			ST_T_MUL: state_d = ST_T_END;
			ST_T_END: state_d = ST_FINISH;
			ST_Q_RD:  state_d = ST_Q_CMP;
			ST_Q_CMP: begin
				if (q_ge) state_d = q_last ? ST_FINISH : ST_Q_RD;
				else      state_d = q_interp ? ST_Q_DIV : ST_FINISH;
			end
			ST_Q_DIV: if (div_done) state_d = ST_Q_MUL;
			ST_Q_MUL: state_d = ST_Q_ADD;
			ST_Q_ADD: state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		duty_we          = 1'b0;
		duty_wa          = '0;
		duty_wd          = min_q;
		speed_we         = 1'b0;
		out_load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc && cmd == CMD_START) duty_we = 1'b1;
				if (acc && cmd == CMD_TICK && tick_run) speed_we = 1'b1;
			end
			ST_T_END: begin
				duty_we = !t_end;
				duty_wa = AW'(count_q);
				duty_wd = nxt_duty;
			end
			ST_Q_CMP: begin
				div_req.start    = q_interp;
				div_req.dividend = sspan_mag[DIV_NUM_W-1:0];
				div_req.divisor  = DIV_DEN_W'(rd_duty_q - lo_duty_q);
			end
			ST_FINISH: out_load = out_free;
			default: ;
		endcase
	end

	// table memories
	always_ff @(posedge clk) begin
		if (duty_we) duty_mem[duty_wa] <= duty_wd;
		if (speed_we) speed_mem[AW'(count_q)] <= rpm_in;
		rd_duty_q  <= duty_mem[idx_q];
		rd_speed_q <= speed_mem[idx_q];
	end

	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			min_q      <= 7'd0;
			max_q      <= 7'd100;
			running_q  <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (paddr[2] == REG_MAX_PERCENT) max_q <= pwdata[PCT_W-1:0];
				else                             min_q <= pwdata[PCT_W-1:0];
			end
			if (acc && cmd == CMD_START) begin
				running_q <= 1'b1;
				count_q   <= '0;
			end
			if (acc && cmd == CMD_TICK) begin
				if (tick_run)       count_q   <= count_q + 1'b1;
				else if (running_q) running_q <= 1'b0;
			end
			if (state_q == ST_T_END && t_end) running_q <= 1'b0;
			if (out_load)      m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_duty_q    <= (cmd == CMD_START) ? min_q : '0;
			res_dvalid_q  <= cmd == CMD_START;
			res_restore_q <= (cmd == CMD_TICK) && running_q && !cnt_lt;
			res_qrpm_q    <= '0;
			res_rvalid_q  <= (cmd == CMD_QUERY) && !running_q;
			pct_q         <= pct_clamp;
			idx_q         <= '0;
			neg_q         <= span[7];
		end
		case (state_q)
			ST_T_DIV: step_q <= (neg_q ? -step_mag : step_mag) + 8'sd1;
			ST_T_MUL: prod_q <= tmul;
			ST_T_END: begin
				if (t_end) begin
					res_restore_q <= 1'b1;
				end else begin
					res_duty_q   <= nxt_duty;
					res_dvalid_q <= 1'b1;
				end
			end
			ST_Q_CMP: begin
				if (q_ge) begin
					lo_duty_q  <= rd_duty_q;
					lo_speed_q <= rd_speed_q;
					if (q_last) res_qrpm_q <= rd_speed_q;
					else        idx_q      <= AW'(idx_next);
				end else if (idx_q == '0) begin
					res_qrpm_q <= rd_speed_q;
				end else if (!q_interp) begin
					res_qrpm_q <= lo_speed_q;
				end else begin
					neg_q <= sspan[RPM_W];
				end
			end
			ST_Q_DIV: begin
				if (div_done) begin
					slope_q <= neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
				end
			end
			ST_Q_MUL: prod_q <= qmul;
			ST_Q_ADD: res_qrpm_q <= qsat;
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= {res_rvalid_q, res_qrpm_q, HELD_W'(count_q), running_q,
			              res_restore_q, res_dvalid_q, res_duty_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_MAX_PERCENT) ? {25'd0, max_q} : {25'd0, min_q};

endmodule

FILE: rtl/fcsi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
module fcsi_div
	import fcsi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic [DIV_NUM_W-1:0] quo,
	output logic                 done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 trial_ge;

	assign trial     = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial_ge  = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule
